>>> rtl/brff_pkg.sv
// Package with the shared constants, types and codes of the bitmap range fill and search block.
`timescale 1ns / 1ps
package brff_pkg;

  localparam int TOTAL_BITS = 4096;
  localparam int WORD_BITS  = 64;
  localparam int WORDS      = TOTAL_BITS / WORD_BITS;
  localparam int IDX_W      = $clog2(TOTAL_BITS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WADDR_W    = $clog2(WORDS);

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FOUND     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_BAD       = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RUN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       load;
    logic       issue;
    logic       run;
    logic       res_load;
    logic [1:0] res_code;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic empty;
    logic is_find;
    logic last;
    logic hit;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/brff_dp.sv
// Datapath of the bitmap block: word store, range masks, match search and result register.
`timescale 1ns / 1ps
module brff_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  brff_pkg::cmd_t        cmd,
  output brff_pkg::sts_t        sts,
  input  logic                  func,
  input  logic [11:0]           offset,
  input  logic [12:0]           num_bits,
  input  logic [12:0]           search_end,
  input  logic                  value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [11:0]           found_index
);
  import brff_pkg::*;

  localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};

  function automatic logic [BIT_W-1:0] first_one(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORDS-1:0]     valid;
  logic [WORD_BITS-1:0] mem_q;
  logic                 vld_q;

  logic                 func_q;
  logic [IDX_W-1:0]     off_q;
  logic [CNT_W-1:0]     num_q;
  logic [CNT_W-1:0]     se_q;
  logic                 value_q;

  logic [WADDR_W-1:0]   cw;
  logic [IDX_W-1:0]     found;

  logic [CNT_W:0]       sum;
  logic [CNT_W-1:0]     end_w;
  logic [CNT_W-1:0]     end_m1;
  logic [WADDR_W-1:0]   lo_w;
  logic [BIT_W-1:0]     lo_b;
  logic [WADDR_W:0]     hi_w;
  logic [BIT_W-1:0]     hi_b;
  logic [WADDR_W-1:0]   last_w;
  logic [WADDR_W-1:0]   raddr;
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] wdata;
  logic [WORD_BITS-1:0] match;
  logic                 wen;

  assign sum    = {1'b0, num_q} + {2'b00, off_q};
  assign end_w  = func_q ? se_q : sum[CNT_W-1:0];
  assign end_m1 = end_w - 1'b1;
  assign lo_w   = off_q[IDX_W-1:BIT_W];
  assign lo_b   = off_q[BIT_W-1:0];
  assign hi_w   = end_w[CNT_W-1:BIT_W];
  assign hi_b   = end_w[BIT_W-1:0];
  assign last_w = end_m1[IDX_W-1:BIT_W];

  assign rdata   = vld_q ? mem_q : '0;
  assign lo_mask = (cw == lo_w) ? (ALL_ONES << lo_b) : ALL_ONES;
  assign hi_mask = ({1'b0, cw} < hi_w) ? ALL_ONES : ~(ALL_ONES << hi_b);
  assign mask    = lo_mask & hi_mask;
  assign wdata   = value_q ? (rdata | mask) : (rdata & ~mask);
  assign match   = (value_q ? rdata : ~rdata) & mask;
  assign wen     = cmd.run && !func_q;
  assign raddr   = cmd.issue ? lo_w : cw + 1'b1;

  always_comb begin
    if (func_q) begin
      sts.bad = ({1'b0, off_q} > se_q) || (se_q > CNT_W'(TOTAL_BITS));
    end else begin
      sts.bad = (num_q == '0) || (sum > (CNT_W + 1)'(TOTAL_BITS));
    end
    sts.empty    = ({1'b0, off_q} == se_q);
    sts.is_find  = func_q;
    sts.last     = (cw == last_w);
    sts.hit      = func_q && (match != '0);
    sts.out_free = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[cw] <= wdata;
    end
    mem_q <= mem[raddr];
    vld_q <= valid[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wen) begin
      valid[cw] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q  <= func;
      off_q   <= offset;
      num_q   <= num_bits;
      se_q    <= search_end;
      value_q <= value;
    end
    if (cmd.issue) begin
      cw <= lo_w;
    end else if (cmd.run) begin
      cw <= cw + 1'b1;
      found <= {cw, first_one(match)};
    end
    if (cmd.res_load) begin
      status      <= cmd.res_code;
      found_index <= (cmd.res_code == ST_FOUND) ? found : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> rtl/brff_ctrl.sv
// Controller state machine that sequences argument checks, the word walk and the result.
`timescale 1ns / 1ps
module brff_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output brff_pkg::cmd_t cmd,
  input  brff_pkg::sts_t sts
);
  import brff_pkg::*;

  state_t     state;
  state_t     state_next;
  logic [1:0] code;
  logic [1:0] code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= ST_DONE;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  always_comb begin
    state_next   = state;
    code_next    = code;
    in_stall     = 1'b1;
    cmd.load     = 1'b0;
    cmd.issue    = 1'b0;
    cmd.run      = 1'b0;
    cmd.res_load = 1'b0;
    cmd.res_code = code;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.bad) begin
          code_next  = ST_BAD;
          state_next = S_DONE;
        end else if (sts.is_find && sts.empty) begin
          code_next  = ST_NOT_FOUND;
          state_next = S_DONE;
        end else begin
          cmd.issue  = 1'b1;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        cmd.run = 1'b1;
        if (sts.hit) begin
          code_next  = ST_FOUND;
          state_next = S_DONE;
        end else if (sts.last) begin
          code_next  = sts.is_find ? ST_NOT_FOUND : ST_DONE;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/bitmap_range_fill_find_first_top.sv
// Top level of the bitmap range fill and first-match search block.
//
// The block keeps a 4096-bit bitmap in 64 words of 64 bits, cleared at reset.
// An input transfer carries func, offset, num_bits, search_end and value; a
// change sets or clears a bit range, a find returns the first bit equal to value.
// Every input transfer yields exactly one output transfer with status and
// found_index.
// One item passes through setup (argument load and check), a walk of one store
// word per cycle (up to 64 words touched) and a load of the result register.
// The single read and write port of the word store sets the pace of the walk.
// Bad arguments and an empty search skip the walk and go from the check to the result load.
// The block works on one item at a time and takes the next input transfer as
// soon as the previous result sits in the output register.
// While the receiver stalls, the result holds and a finished item waits for
// the output register to free up.
// Reset empties the output register and marks every store word as zero.
`timescale 1ns / 1ps
module bitmap_range_fill_find_first_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [11:0] offset,
  input  logic [12:0] num_bits,
  input  logic [12:0] search_end,
  input  logic        value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [11:0] found_index
);
  import brff_pkg::*;

  cmd_t cmd;
  sts_t sts;

  brff_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  brff_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .func        (func),
    .offset      (offset),
    .num_bits    (num_bits),
    .search_end  (search_end),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found_index (found_index)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while an item was still in work");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_FOUND) |-> (found_index == '0))
    else $error("found_index nonzero without a match");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result pending right after reset");

endmodule

>>> test/tb_bitmap_range_fill_find_first_top.sv
// Self-checking testbench for the bitmap range fill and first-match search block.
`timescale 1ns / 1ps
module tb_bitmap_range_fill_find_first_top;
  import brff_pkg::*;

  localparam logic FUNC_CHANGE = 1'b0;
  localparam logic FUNC_FIND   = 1'b1;
  localparam int   RANDOM_OPS  = 2000;
  localparam int   CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic              drain_first;
    logic              func;
    logic [IDX_W-1:0]  offset;
    logic [CNT_W-1:0]  num_bits;
    logic [CNT_W-1:0]  search_end;
    logic              value;
  } op_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] found_index;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [1:0] status;
  logic [11:0] found_index;
  op_t cur_op = '0;

  op_t pending_ops[$];
  answer_t expected_answers[$];
  logic [WORD_BITS-1:0] shadow_map [WORDS];
  int accepted_count = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  logic calm;

  bitmap_range_fill_find_first_top u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (cur_op.func),
    .offset      (cur_op.offset),
    .num_bits    (cur_op.num_bits),
    .search_end  (cur_op.search_end),
    .value       (cur_op.value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found_index (found_index)
  );

  assign calm = (accepted_count >= 800) && (accepted_count < 1200);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic op_t make_op(logic f, int off, int nb, int se, logic v, logic drain);
    op_t op;
    op.drain_first = drain;
    op.func = f;
    op.offset = IDX_W'(off);
    op.num_bits = CNT_W'(nb);
    op.search_end = CNT_W'(se);
    op.value = v;
    return op;
  endfunction

  function automatic answer_t apply_bitmap_op(op_t op);
    answer_t r;
    int first;
    int stop;
    int i;
    r.status = ST_DONE;
    r.found_index = '0;
    first = int'(op.offset);
    if (op.func == FUNC_CHANGE) begin
      stop = first + int'(op.num_bits);
      if (op.num_bits == 0 || stop > TOTAL_BITS) begin
        r.status = ST_BAD;
      end else begin
        for (i = first; i < stop; i++)
          shadow_map[WADDR_W'(i / WORD_BITS)][BIT_W'(i % WORD_BITS)] = op.value;
      end
    end else begin
      stop = int'(op.search_end);
      if (first > stop || stop > TOTAL_BITS) begin
        r.status = ST_BAD;
      end else begin
        r.status = ST_NOT_FOUND;
        for (i = first; i < stop && r.status == ST_NOT_FOUND; i++) begin
          if (shadow_map[WADDR_W'(i / WORD_BITS)][BIT_W'(i % WORD_BITS)] == op.value) begin
            r.status = ST_FOUND;
            r.found_index = IDX_W'(i);
          end
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // Driver: predicts each accepted transfer and presents the next pending item.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_answers.push_back(apply_bitmap_op(cur_op));
        accepted_count <= accepted_count + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_ops.size() != 0 &&
            (!pending_ops[0].drain_first || expected_answers.size() == 0) &&
            (calm || $urandom_range(0, 99) >= 13)) begin
          cur_op <= pending_ops.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result transfer against the oldest prediction.
  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 13);
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("unexpected result status", int'(status), -1);
        end else begin
          want = expected_answers.pop_front();
          if (status !== want.status)
            report_mismatch("status", int'(status), int'(want.status));
          if (found_index !== want.found_index)
            report_mismatch("found_index", int'(found_index), int'(want.found_index));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    op_t op;
    int k;
    int sel;
    int off;
    int room;
    int len;
    int span;
    logic drain;
    for (k = 0; k < WORDS; k++) shadow_map[WADDR_W'(k)] = '0;

    pending_ops.push_back(make_op(FUNC_FIND, 0, 0, 4096, 1'b0, 1'b0));
    pending_ops.push_back(make_op(FUNC_FIND, 0, 0, 4096, 1'b1, 1'b0));
    pending_ops.push_back(make_op(FUNC_CHANGE, 0, 4096, 0, 1'b1, 1'b0));
    pending_ops.push_back(make_op(FUNC_FIND, 0, 0, 4096, 1'b0, 1'b0));
    pending_ops.push_back(make_op(FUNC_CHANGE, 4095, 1, 8191, 1'b0, 1'b0));
    pending_ops.push_back(make_op(FUNC_FIND, 0, 8191, 4096, 1'b0, 1'b0));
    pending_ops.push_back(make_op(FUNC_CHANGE, 12, 0, 4096, 1'b1, 1'b0));
    pending_ops.push_back(make_op(FUNC_CHANGE, 4095, 2, 0, 1'b1, 1'b0));
    pending_ops.push_back(make_op(FUNC_CHANGE, 0, 8191, 0, 1'b0, 1'b0));
    pending_ops.push_back(make_op(FUNC_FIND, 0, 0, 4097, 1'b0, 1'b0));
    pending_ops.push_back(make_op(FUNC_FIND, 4095, 0, 8191, 1'b1, 1'b0));
    pending_ops.push_back(make_op(FUNC_FIND, 100, 0, 99, 1'b1, 1'b0));
    pending_ops.push_back(make_op(FUNC_FIND, 5, 0, 5, 1'b1, 1'b0));
    pending_ops.push_back(make_op(FUNC_FIND, 4095, 0, 4096, 1'b0, 1'b0));
    pending_ops.push_back(make_op(FUNC_CHANGE, 0, 4096, 0, 1'b0, 1'b0));
    pending_ops.push_back(make_op(FUNC_CHANGE, 63, 2, 0, 1'b1, 1'b0));
    pending_ops.push_back(make_op(FUNC_FIND, 0, 0, 4096, 1'b1, 1'b0));
    pending_ops.push_back(make_op(FUNC_FIND, 65, 0, 4096, 1'b1, 1'b0));
    pending_ops.push_back(make_op(FUNC_FIND, 64, 0, 128, 1'b0, 1'b0));
    pending_ops.push_back(make_op(FUNC_FIND, 4095, 4096, 4095, 1'b0, 1'b0));
    pending_ops.push_back(make_op(FUNC_CHANGE, 4032, 64, 0, 1'b1, 1'b0));
    pending_ops.push_back(make_op(FUNC_FIND, 4000, 0, 4096, 1'b1, 1'b0));

    for (k = 0; k < RANDOM_OPS; k++) begin
      drain = (k == 0) || (k == RANDOM_OPS / 2);
      sel = $urandom_range(0, 99);
      off = $urandom_range(0, TOTAL_BITS - 1);
      room = TOTAL_BITS - off;
      if (sel < 40) begin
        sel = $urandom_range(0, 9);
        if (sel < 7) len = $urandom_range(1, 64);
        else if (sel < 9) len = $urandom_range(1, 512);
        else len = $urandom_range(1, TOTAL_BITS);
        if (len > room) len = room;
        op = make_op(FUNC_CHANGE, off, len, $urandom, 1'($urandom), drain);
      end else if (sel < 85) begin
        span = ($urandom_range(0, 4) == 0) ? TOTAL_BITS : $urandom_range(0, 128);
        if (span > room) span = room;
        op = make_op(FUNC_FIND, off, $urandom, off + $urandom_range(0, span),
                     1'($urandom), drain);
      end else begin
        op = make_op(1'($urandom), $urandom, $urandom, $urandom, 1'($urandom), drain);
      end
      pending_ops.push_back(op);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_ops.size() != 0 || in_valid || expected_answers.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (expected_answers.size() != 0)
      report_mismatch("results left over", 0, expected_answers.size());
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> bitmap_range_fill_find_first_top.f
rtl/brff_pkg.sv
rtl/brff_dp.sv
rtl/brff_ctrl.sv
rtl/bitmap_range_fill_find_first_top.sv
test/tb_bitmap_range_fill_find_first_top.sv
